// ===== sv/stt_pkg.sv =====
// Shared types and constants for the software timer table unit.
// No dependencies; compiled first.
package stt_pkg;

	// table geometry
	localparam int NUM_TIMERS = 8;
	localparam int TW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
	localparam int COUNT_W = 32;

	// request and result field widths
	localparam int MODE_W = 3;
	localparam int INDEX_W = 3;
	localparam int STATUS_W = 2;

	// operation codes carried by a request
	typedef enum logic [MODE_W-1:0] {
		MODE_TICK   = 3'd0,
		MODE_START  = 3'd1,
		MODE_STOP   = 3'd2,
		MODE_STATUS = 3'd3,
		MODE_VALUE  = 3'd4
	} mode_e_t;

	// status codes returned by a status read
	typedef enum logic [STATUS_W-1:0] {
		ST_EXPIRED     = 2'd0,
		ST_WAITING     = 2'd1,
		ST_NOT_STARTED = 2'd2
	} status_e_t;

	// sequencer states
	typedef enum logic [1:0] {
		S_IDLE,
		S_OP,
		S_TICK
	} state_t;

	// one timer entry as stored in the table
	typedef struct packed {
		logic               running;
		logic               expired;
		logic [COUNT_W-1:0] count;
	} timer_entry_t;

	// table access for one cycle
	typedef struct packed {
		logic         rd_en;
		logic [TW-1:0] rd_addr;
		logic         wr_en;
		logic [TW-1:0] wr_addr;
		timer_entry_t wr_data;
	} tbl_req_t;

endpackage

// ===== sv/stt_cmd_if.sv =====
// Request channel of the software timer table unit.
// Depends on stt_pkg.
interface stt_cmd_if;
	import stt_pkg::*;

	logic                valid;
	logic                ready;
	logic [MODE_W-1:0]   mode;
	logic [INDEX_W-1:0]  timer_index;
	logic [COUNT_W-1:0]  interval_value;

	modport source(output valid, output mode, output timer_index, output interval_value,
		input ready);
	modport sink(input valid, input mode, input timer_index, input interval_value,
		output ready);
endinterface

// ===== sv/stt_rsp_if.sv =====
// Result channel of the software timer table unit.
// Depends on stt_pkg.
interface stt_rsp_if;
	import stt_pkg::*;

	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [COUNT_W-1:0]  remaining;

	modport source(output valid, output status, output remaining, input ready);
	modport sink(input valid, input status, input remaining, output ready);
endinterface

// ===== sv/stt_table.sv =====
// Timer entry store: one synchronous memory with a registered read port,
// plus per-entry valid bits so unwritten entries read as all zero. Uses stt_pkg.
module stt_table (
	input  logic                  clk,
	input  logic                  arst_n,
	input  stt_pkg::tbl_req_t     req,
	output stt_pkg::timer_entry_t rd_entry
);
	import stt_pkg::*;

	timer_entry_t mem [NUM_TIMERS];
	logic [NUM_TIMERS-1:0] vld_q;
	timer_entry_t rd_data_q;
	logic rd_vld_q;

	// memory array: one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= req.wr_data;
		end
		if (req.rd_en) begin
			rd_data_q <= mem[req.rd_addr];
		end
	end

	// valid bits stand in for the all-zero reset contents
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (req.wr_en) begin
				vld_q[req.wr_addr] <= 1'b1;
			end
			if (req.rd_en) begin
				rd_vld_q <= vld_q[req.rd_addr];
			end
		end
	end

	assign rd_entry = rd_vld_q ? rd_data_q : '0;
endmodule

// ===== sv/software_timer_table_unit.sv =====
// Software timer table unit: top level with request sequencer and result register.
// Depends on stt_pkg, stt_cmd_if, stt_rsp_if and stt_table.
//
// Holds NUM_TIMERS countdown timers in a single-port-per-direction memory and
// returns exactly one result per request. Start, stop, status read and value
// read first read the entry, then update it and load the result register. A
// tick walks the whole table, one entry per cycle through the memory's read and
// write ports; its last write and result load wait for a free result slot. A new
// request is taken once the previous one has loaded its result; a result that is
// not yet taken only holds up the final step of the following request.
module software_timer_table_unit (
	input logic clk,
	input logic arst_n,
	stt_cmd_if.sink cmd,
	stt_rsp_if.source rsp
);
	import stt_pkg::*;

	state_t state_q, state_d;
	logic [MODE_W-1:0] mode_q;
	logic [TW-1:0] addr_q;
	logic [COUNT_W-1:0] ival_q;
	logic idx_ok_q;

	logic rsp_valid_q;
	logic [STATUS_W-1:0] status_q;
	logic [COUNT_W-1:0] remaining_q;

	tbl_req_t tbl;
	timer_entry_t entry;
	timer_entry_t new_entry;
	logic op_wr;
	logic [STATUS_W-1:0] op_status;
	logic [COUNT_W-1:0] op_remaining;

	logic accept;
	logic slot_free;
	logic tick_last;
	logic load_rsp;

	assign accept = cmd.valid && cmd.ready;
	assign slot_free = !rsp_valid_q || rsp.ready;
	assign tick_last = (addr_q == TW'(NUM_TIMERS - 1));

	stt_table u_table (
		.clk(clk),
		.arst_n(arst_n),
		.req(tbl),
		.rd_entry(entry)
	);

	// entry update and result for the current request
	always_comb begin
		new_entry = entry;
		op_wr = 1'b0;
		op_status = ST_EXPIRED;
		op_remaining = '0;
		if (state_q == S_TICK) begin
			op_wr = 1'b1;
			if (entry.running && !entry.expired) begin
				if (entry.count != '0) begin
					new_entry.count = entry.count - COUNT_W'(1);
				end else begin
					new_entry.expired = 1'b1;
				end
			end
		end else begin
			case (mode_q)
				MODE_START: begin
					if (idx_ok_q) begin
						new_entry.running = 1'b1;
						new_entry.expired = 1'b0;
						new_entry.count = ival_q;
						op_wr = 1'b1;
					end
				end
				MODE_STOP: begin
					if (idx_ok_q) begin
						new_entry.running = 1'b0;
						new_entry.expired = 1'b0;
						op_wr = 1'b1;
					end
				end
				MODE_STATUS: begin
					if (idx_ok_q && entry.running) begin
						if (entry.expired) begin
							new_entry.running = 1'b0;
							new_entry.expired = 1'b0;
							op_wr = 1'b1;
							op_status = ST_EXPIRED;
						end else begin
							op_status = ST_WAITING;
						end
					end else begin
						op_status = ST_NOT_STARTED;
					end
				end
				MODE_VALUE: begin
					if (idx_ok_q) begin
						op_remaining = entry.count;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = (cmd.mode == MODE_TICK) ? S_TICK : S_OP;
				end
			end
			S_OP: begin
				if (slot_free) begin
					state_d = S_IDLE;
				end
			end
			S_TICK: begin
				if (tick_last && slot_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// sequencer outputs: table access, request ready and result load
	always_comb begin
		tbl = '0;
		cmd.ready = 1'b0;
		load_rsp = 1'b0;
		case (state_q)
			S_IDLE: begin
				cmd.ready = 1'b1;
				tbl.rd_en = cmd.valid;
				tbl.rd_addr = (cmd.mode == MODE_TICK) ? '0 : TW'(cmd.timer_index);
			end
			S_OP: begin
				if (slot_free) begin
					load_rsp = 1'b1;
					tbl.wr_en = op_wr;
				end
			end
			S_TICK: begin
				if (!tick_last) begin
					tbl.wr_en = 1'b1;
					tbl.rd_en = 1'b1;
					tbl.rd_addr = addr_q + TW'(1);
				end else if (slot_free) begin
					tbl.wr_en = 1'b1;
					load_rsp = 1'b1;
				end
			end
			default: begin
			end
		endcase
		tbl.wr_addr = addr_q;
		tbl.wr_data = new_entry;
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_rsp) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// request fields and walk address
	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q <= cmd.mode;
			ival_q <= cmd.interval_value;
			idx_ok_q <= (32'(cmd.timer_index) < NUM_TIMERS);
			addr_q <= (cmd.mode == MODE_TICK) ? '0 : TW'(cmd.timer_index);
		end else if (state_q == S_TICK && !tick_last) begin
			addr_q <= addr_q + TW'(1);
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (load_rsp) begin
			status_q <= op_status;
			remaining_q <= op_remaining;
		end
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.status = status_q;
	assign rsp.remaining = remaining_q;

	// an accepted request always leaves idle
	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q != S_IDLE)
		else $error("request accepted but sequencer stayed idle");

	// a new result appears only as a request finishes
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp.valid) |-> ($past(state_q) == S_OP || $past(state_q) == S_TICK))
		else $error("result appeared without a request in progress");

	// the tick walk steps through entries one per cycle
	a_tick_walk: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_TICK && !tick_last) |=> addr_q == $past(addr_q) + TW'(1))
		else $error("tick walk skipped or repeated an entry");
endmodule

// ===== verif/tb_software_timer_table_unit.sv =====
`timescale 1ns / 1ps
// Testbench for software_timer_table_unit: a directed table of timer requests, then random
// requests, each result checked in order against a stated value or a shadow timer table.
// Depends on stt_pkg, stt_cmd_if, stt_rsp_if and the unit's RTL.
module tb_software_timer_table_unit;
	import stt_pkg::*;

	// mode codes the unit does not define
	localparam logic [MODE_W-1:0] MODE_SPARE_LO = 3'd5;
	localparam logic [MODE_W-1:0] MODE_SPARE_HI = 3'd7;

	localparam int RANDOM_REQUESTS = 950;
	localparam int STALL_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 2 * (NUM_TIMERS + 1) + 10;

	typedef struct {
		logic [STATUS_W-1:0] status;
		logic [COUNT_W-1:0]  remaining;
	} timer_result_t;

	typedef struct {
		logic [MODE_W-1:0]  mode;
		logic [INDEX_W-1:0] index;
		logic [COUNT_W-1:0] interval;
		bit                 known;
		timer_result_t      result;
	} directed_row_t;

	logic clk;
	logic arst_n;

	stt_cmd_if cmd_ch();
	stt_rsp_if rsp_ch();

	software_timer_table_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd_ch),
		.rsp(rsp_ch)
	);

	// shadow copy of the timer table
	bit                 run_flag [NUM_TIMERS];
	bit                 exp_flag [NUM_TIMERS];
	logic [COUNT_W-1:0] count_left [NUM_TIMERS];

	timer_result_t pending_results[$];
	directed_row_t directed_rows[$];
	int error_count = 0;
	int sent_count = 0;
	int idle_cycles = 0;

	// clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// applies one request to the shadow table and returns the result it gives
	function automatic timer_result_t apply_timer_request(input logic [MODE_W-1:0] mode,
		input logic [INDEX_W-1:0] index, input logic [COUNT_W-1:0] interval);
		timer_result_t r;
		bit in_range;
		r.status = '0;
		r.remaining = '0;
		in_range = (int'(index) < NUM_TIMERS);
		case (mode)
		MODE_TICK: begin
			for (int t = 0; t < NUM_TIMERS; t++) begin
				if (run_flag[t] && !exp_flag[t]) begin
					if (count_left[t] != '0)
						count_left[t] = count_left[t] - 1'b1;
					else
						exp_flag[t] = 1'b1;
				end
			end
		end
		MODE_START: begin
			if (in_range) begin
				count_left[index] = interval;
				exp_flag[index] = 1'b0;
				run_flag[index] = 1'b1;
			end
		end
		MODE_STOP: begin
			if (in_range) begin
				run_flag[index] = 1'b0;
				exp_flag[index] = 1'b0;
			end
		end
		MODE_STATUS: begin
			if (in_range && run_flag[index]) begin
				if (exp_flag[index]) begin
					// reporting expiry also stops the timer
					run_flag[index] = 1'b0;
					exp_flag[index] = 1'b0;
					r.status = ST_EXPIRED;
				end else begin
					r.status = ST_WAITING;
				end
			end else begin
				r.status = ST_NOT_STARTED;
			end
		end
		MODE_VALUE: begin
			if (in_range)
				r.remaining = count_left[index];
		end
		default: ;
		endcase
		return r;
	endfunction

	// wait before a request or result, with calm stretches that never wait
	function automatic int pick_wait(input int n);
		if ((n / 48) % 4 == 3)
			return 0;
		return $urandom_range(0, 7);
	endfunction

	task automatic add_row(input logic [MODE_W-1:0] mode, input logic [INDEX_W-1:0] index,
		input logic [COUNT_W-1:0] interval, input bit known,
		input logic [STATUS_W-1:0] status, input logic [COUNT_W-1:0] remaining);
		directed_row_t row;
		row.mode = mode;
		row.index = index;
		row.interval = interval;
		row.known = known;
		row.result.status = status;
		row.result.remaining = remaining;
		directed_rows.push_back(row);
	endtask

	// drives one request, waits for its acceptance and records the expected result
	task automatic send_request(input logic [MODE_W-1:0] mode, input logic [INDEX_W-1:0] index,
		input logic [COUNT_W-1:0] interval, input bit known, input timer_result_t given);
		int gap;
		timer_result_t predicted;
		gap = pick_wait(sent_count);
		if (gap > 0) begin
			cmd_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_ch.valid <= 1'b1;
		cmd_ch.mode <= mode;
		cmd_ch.timer_index <= index;
		cmd_ch.interval_value <= interval;
		do @(posedge clk); while (!cmd_ch.ready);
		predicted = apply_timer_request(mode, index, interval);
		pending_results.push_back(known ? given : predicted);
		sent_count++;
	endtask

	// request stimulus
	initial begin : stimulus
		timer_result_t none;
		logic [MODE_W-1:0] mode;
		logic [INDEX_W-1:0] index;
		logic [COUNT_W-1:0] interval;
		int pick;
		int shape;
		none.status = '0;
		none.remaining = '0;
		arst_n <= 1'b0;
		cmd_ch.valid <= 1'b0;
		cmd_ch.mode <= MODE_TICK;
		cmd_ch.timer_index <= '0;
		cmd_ch.interval_value <= '0;
		for (int t = 0; t < NUM_TIMERS; t++) begin
			run_flag[t] = 1'b0;
			exp_flag[t] = 1'b0;
			count_left[t] = '0;
		end

		// after reset: nothing started
		add_row(MODE_VALUE, 3'd0, '1, 1'b1, '0, '0);
		add_row(MODE_STATUS, 3'd7, '0, 1'b1, ST_NOT_STARTED, '0);
		// undefined modes do nothing
		add_row(MODE_SPARE_LO, 3'd2, '0, 1'b1, '0, '0);
		add_row(MODE_SPARE_HI, 3'd5, '1, 1'b1, '0, '0);
		// zero interval expires on the first tick
		add_row(MODE_START, 3'd0, '0, 1'b1, '0, '0);
		add_row(MODE_STATUS, 3'd0, '0, 1'b1, ST_WAITING, '0);
		add_row(MODE_TICK, 3'd0, '0, 1'b1, '0, '0);
		add_row(MODE_STATUS, 3'd0, '0, 1'b1, ST_EXPIRED, '0);
		add_row(MODE_STATUS, 3'd0, '0, 1'b1, ST_NOT_STARTED, '0);
		add_row(MODE_VALUE, 3'd0, '0, 1'b1, '0, '0);
		// largest interval
		add_row(MODE_START, 3'd7, '1, 1'b1, '0, '0);
		add_row(MODE_TICK, 3'd0, '0, 1'b0, '0, '0);
		add_row(MODE_VALUE, 3'd7, '0, 1'b0, '0, '0);
		// interval of one expires after two ticks
		add_row(MODE_START, 3'd3, 32'd1, 1'b0, '0, '0);
		add_row(MODE_TICK, 3'd0, '0, 1'b0, '0, '0);
		add_row(MODE_TICK, 3'd0, '0, 1'b0, '0, '0);
		add_row(MODE_STATUS, 3'd3, '0, 1'b0, '0, '0);
		// stop keeps the count in place
		add_row(MODE_START, 3'd5, 32'h5555_5555, 1'b0, '0, '0);
		add_row(MODE_STOP, 3'd5, 32'hAAAA_AAAA, 1'b0, '0, '0);
		add_row(MODE_VALUE, 3'd5, '0, 1'b0, '0, '0);
		add_row(MODE_START, 3'd2, 32'hAAAA_AAAA, 1'b0, '0, '0);
		add_row(MODE_TICK, 3'd0, '0, 1'b0, '0, '0);
		add_row(MODE_VALUE, 3'd2, '0, 1'b0, '0, '0);
		// a stopped timer ignores ticks
		add_row(MODE_STOP, 3'd7, '0, 1'b0, '0, '0);
		add_row(MODE_TICK, 3'd0, '0, 1'b0, '0, '0);
		add_row(MODE_VALUE, 3'd7, '0, 1'b0, '0, '0);

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[i])
			send_request(directed_rows[i].mode, directed_rows[i].index,
				directed_rows[i].interval, directed_rows[i].known, directed_rows[i].result);

		// random requests, mostly short intervals so that timers run out
		for (int n = 0; n < RANDOM_REQUESTS; n++) begin
			pick = $urandom_range(0, 99);
			index = INDEX_W'($urandom_range(0, (1 << INDEX_W) - 1));
			interval = $urandom;
			if (pick < 35) begin
				mode = MODE_TICK;
			end else if (pick < 52) begin
				mode = MODE_START;
				shape = $urandom_range(0, 9);
				if (shape < 7)
					interval = $urandom_range(0, 6);
				else if (shape == 7)
					interval = '1 - $urandom_range(0, 3);
			end else if (pick < 60) begin
				mode = MODE_STOP;
			end else if (pick < 80) begin
				mode = MODE_STATUS;
			end else if (pick < 95) begin
				mode = MODE_VALUE;
			end else begin
				mode = MODE_W'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI));
			end
			send_request(mode, index, interval, 1'b0, none);
		end
		cmd_ch.valid <= 1'b0;

		wait (pending_results.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	// result sink with random stalls, checks each result against the oldest expectation
	initial begin : result_sink
		int stall;
		int taken;
		timer_result_t want;
		taken = 0;
		rsp_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			stall = pick_wait(taken + 24);
			if (stall > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			do @(posedge clk); while (!rsp_ch.valid);
			taken++;
			if (pending_results.size() == 0) begin
				$error("result with no request outstanding: status %0d remaining %0h",
					rsp_ch.status, rsp_ch.remaining);
				error_count++;
			end else begin
				want = pending_results.pop_front();
				if (rsp_ch.status !== want.status) begin
					$error("status mismatch: expected %0d, actual %0d",
						want.status, rsp_ch.status);
					error_count++;
				end
				if (rsp_ch.remaining !== want.remaining) begin
					$error("remaining mismatch: expected %0h, actual %0h",
						want.remaining, rsp_ch.remaining);
					error_count++;
				end
			end
		end
	end

	// watchdog on cycles with no request or result moving
	always @(posedge clk) begin
		if (!arst_n || (cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

endmodule
